[src/mwb_pkg.sv]
`default_nettype none
package mwb_pkg;

	// ramp fixed-point format
	localparam int RAMP_FRAC_BITS = 16;

	// field widths
	localparam int PIX_W    = 8;
	localparam int GAIN_W   = 23;
	localparam int OFFS_W   = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int WEIGHT_W = 9;
	localparam int PROD_W   = 2 * PIX_W;
	localparam int RAMP_W   = GAIN_W + PIX_W;
	localparam int SUM_W    = OFFS_W + 1;

	// full weight: source A only
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(256);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SRC_A        = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_SRC_B        = CFG_IDX_W'(4);

	// reset values
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

	// load strobes and source selects for the blend lanes
	typedef struct packed {
		logic ld_s4;
		logic ld_s5;
		logic use_a;
		logic use_b;
	} mwb_ctrl_t;

endpackage
`default_nettype wire

[src/mwb_lane.sv]
`default_nettype none
module mwb_lane (
	input  wire                            clk,
	input  wire mwb_pkg::mwb_ctrl_t        ctrl,
	input  wire [mwb_pkg::PIX_W-1:0]       a_s3,
	input  wire [mwb_pkg::PIX_W-1:0]       b_s3,
	input  wire [mwb_pkg::WEIGHT_W-1:0]    weight_s3,
	output logic [mwb_pkg::PIX_W-1:0]      pix_s5
);
	import mwb_pkg::*;

	logic [WEIGHT_W-1:0] weight_b;
	logic [PROD_W-1:0]   prod_a_s4;
	logic [PROD_W-1:0]   prod_b_s4;
	logic [PROD_W-1:0]   acc;

	// complementary weight for source B
	assign weight_b = WEIGHT_FULL - weight_s3;

	// weight both sources, drop an absent one
	always_ff @(posedge clk) begin
		if (ctrl.ld_s4) begin
			prod_a_s4 <= ctrl.use_a ? PROD_W'(a_s3) * PROD_W'(weight_s3) : '0;
			prod_b_s4 <= ctrl.use_b ? PROD_W'(b_s3) * PROD_W'(weight_b) : '0;
		end
	end

	// sum and scale back to a pixel; the sum never exceeds 255 * 256
	assign acc = prod_a_s4 + prod_b_s4;

	always_ff @(posedge clk) begin
		if (ctrl.ld_s5) begin
			pix_s5 <= acc[PROD_W-1:PIX_W];
		end
	end

endmodule
`default_nettype wire

[src/mask_wipe_blend_core.sv]
`default_nettype none
// Pipeline: an accepted input beat passes five registered stages, s1 to s5, to its output beat.
// Throughput: one pixel per clock; a beat enters every cycle unless the
// output stalls, and the five-stage valid chain takes up empty slots first.
// Reset (arst_n low, asynchronous): pipeline empties, registers return to
// gain 1.0, offset 0, no inversion, both sources present.
module mask_wipe_blend_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [mwb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [mwb_pkg::CFG_W-1:0]     cfg_data,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [mwb_pkg::PIX_W-1:0]     mask_level,
	input  wire [mwb_pkg::PIX_W-1:0]     a_red,
	input  wire [mwb_pkg::PIX_W-1:0]     a_green,
	input  wire [mwb_pkg::PIX_W-1:0]     a_blue,
	input  wire [mwb_pkg::PIX_W-1:0]     b_red,
	input  wire [mwb_pkg::PIX_W-1:0]     b_green,
	input  wire [mwb_pkg::PIX_W-1:0]     b_blue,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [mwb_pkg::PIX_W-1:0]    out_red,
	output logic [mwb_pkg::PIX_W-1:0]    out_green,
	output logic [mwb_pkg::PIX_W-1:0]    out_blue
);
	import mwb_pkg::*;

	// configuration registers
	logic [GAIN_W-1:0] gain_q;
	logic [OFFS_W-1:0] offset_q;
	logic              invert_q;
	logic              src_a_q;
	logic              src_b_q;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	// payload
	logic [PIX_W-1:0]            mask_s1;
	logic [RAMP_W-1:0]           ramp_s2;
	logic [WEIGHT_W-1:0]         weight_s3;
	logic [2:0][PIX_W-1:0]       a_s1, a_s2, a_s3;
	logic [2:0][PIX_W-1:0]       b_s1, b_s2, b_s3;
	logic [2:0][PIX_W-1:0]       pix_s5;

	logic signed [SUM_W-1:0]     sum;
	logic [SUM_W-1:0]            sum_shr;
	logic [WEIGHT_W-1:0]         weight_nxt;
	mwb_ctrl_t                   ctrl;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			offset_q <= '0;
			invert_q <= 1'b0;
			src_a_q  <= 1'b1;
			src_b_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVEL_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				REG_LEVEL_OFFSET: offset_q <= cfg_data[OFFS_W-1:0];
				REG_INVERT_MASK:  invert_q <= cfg_data[0];
				REG_SRC_A:        src_a_q  <= cfg_data[0];
				REG_SRC_B:        src_b_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the next one advances
	assign en5 = !v_s5 || out_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: capture beat, mirror mask when inversion is enabled
	always_ff @(posedge clk) begin
		if (en1) begin
			mask_s1 <= invert_q ? ~mask_level : mask_level;
			a_s1    <= {a_blue, a_green, a_red};
			b_s1    <= {b_blue, b_green, b_red};
		end
	end

	// stage 2: ramp slope times mask
	always_ff @(posedge clk) begin
		if (en2) begin
			ramp_s2 <= RAMP_W'(gain_q) * RAMP_W'(mask_s1);
			a_s2    <= a_s1;
			b_s2    <= b_s1;
		end
	end

	// stage 3: add offset, floor, clamp to [0, 256]
	assign sum     = $signed({1'b0, ramp_s2}) + $signed({offset_q[OFFS_W-1], offset_q});
	assign sum_shr = SUM_W'(sum) >> RAMP_FRAC_BITS;

	always_comb begin
		if (sum[SUM_W-1]) begin
			weight_nxt = '0;
		end else if (sum_shr > SUM_W'(WEIGHT_FULL)) begin
			weight_nxt = WEIGHT_FULL;
		end else begin
			weight_nxt = sum_shr[WEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			weight_s3 <= weight_nxt;
			a_s3      <= a_s2;
			b_s3      <= b_s2;
		end
	end

	// stages 4 and 5: per-channel blend
	assign ctrl.ld_s4 = en4;
	assign ctrl.ld_s5 = en5;
	assign ctrl.use_a = src_a_q;
	assign ctrl.use_b = src_b_q;

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		mwb_lane u_lane (
			.clk       (clk),
			.ctrl      (ctrl),
			.a_s3      (a_s3[ch]),
			.b_s3      (b_s3[ch]),
			.weight_s3 (weight_s3),
			.pix_s5    (pix_s5[ch])
		);
	end

	assign out_valid = v_s5;
	assign out_red   = pix_s5[0];
	assign out_green = pix_s5[1];
	assign out_blue  = pix_s5[2];

endmodule
`default_nettype wire
